// ===== sv/lbb_pkg.sv =====
// ============================================================================
// lbb_pkg: shared definitions for the line box blur
// Widths, reset values and the command/status bundles that pass between
// the controller and the datapath.
// ============================================================================
package lbb_pkg;

  localparam int PIX_W          = 8;   // pixel width
  localparam int WS_W           = 4;   // window size register width
  localparam int PAD_W          = 3;   // pad is at most seven
  localparam int TAP_W          = 4;   // tap counter, up to 2*pad
  localparam int SUM_W          = 12;  // fifteen pixels of 255
  localparam int SEEN_W         = 4;   // pixel count of the current line
  localparam int QBITS          = 8;   // quotient bits of the divider
  localparam int QCNT_W         = 3;   // divider step counter
  localparam int MAX_WINDOW_DEF = 15;  // default history depth

  localparam logic [WS_W-1:0]   WS_RESET = 4'd3;
  localparam logic [SEEN_W-1:0] PIX_SAT  = 4'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // input transaction accepted this cycle
    logic acc_step;  // add one window tap into the sum
    logic div_step;  // one restoring division step
    logic push;      // move the quotient into the output register
    logic next_out;  // step to the next centre and restart the sum
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_first;  // the arriving pixel releases at least one output
    logic taps_done;   // the current tap is the last of the window
    logic div_done;    // the current division step is the last
    logic more_out;    // further outputs remain for this pixel
    logic out_free;    // the output register can take a new result
  } sts_t;

endpackage

// ===== sv/line_box_blur.sv =====
// ============================================================================
// line_box_blur: one-dimensional box blur over a line of 8-bit pixels
// Odd-window moving average with edge replication at both line ends.
// ============================================================================
// Usage:
//   Pixels enter on the slave stream (s_tdata pixel, s_tlast marks the last
//   pixel of a line); blurred pixels leave on the master stream, m_tlast on
//   the final output of the line. The user must write the window size over
//   cfg_wen/cfg_wdata only while the block is idle, which it does not enforce.
//   The output for position k is released by the transaction that carries
//   pixel k+pad, with pad = window_size/2; the last pixel releases all
//   outputs still pending for the line, up to pad+1 of them.
//   Each output is produced sequentially: the window is summed through the
//   shared accumulator, the sum is divided in the restoring divider and the
//   quotient is moved into the output register. A pixel that releases no
//   output is done once it is accepted. One pixel is worked on at a time;
//   s_tready is high only while the controller waits for input.
//   The output register separates the two streams: while a result waits
//   for m_tready the block still accepts and processes the next pixel, and
//   stalls only when a new result needs the occupied register.
//   Reset (rst, synchronous) clears the history to zeros, the line position,
//   the output valid, and sets the window size to 3.
// ============================================================================
module line_box_blur #(
  parameter int MAX_WINDOW = lbb_pkg::MAX_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [lbb_pkg::WS_W-1:0]  cfg_wdata,   // window_size
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [lbb_pkg::PIX_W-1:0] s_tdata,     // pixel_in
  input  logic                      s_tlast,     // line_end
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lbb_pkg::PIX_W-1:0] m_tdata,     // pixel_out
  output logic                      m_tlast      // last_out
);

  lbb_pkg::cmd_t cmd;
  lbb_pkg::sts_t sts;

  // The controller only sequences; all arithmetic and storage sit in the
  // datapath.
  lbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbb_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sv/lbb_ctrl.sv =====
// ============================================================================
// lbb_ctrl: sequencing for the line box blur
// Accepts one pixel at a time and walks each output through window
// accumulation, division and hand-off to the output register.
// ============================================================================
module lbb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  lbb_pkg::sts_t sts,
  output lbb_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.emit_first) begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.taps_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.more_out) begin
            cmd.next_out = 1'b1;
            state_next   = ST_ACC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lbb_dp.sv =====
// ============================================================================
// lbb_dp: datapath of the line box blur
// Pixel history, line position, window accumulator, restoring divider,
// output register and the window size register.
// ============================================================================
module lbb_dp #(
  parameter int MAX_WINDOW = lbb_pkg::MAX_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [lbb_pkg::WS_W-1:0]  cfg_wdata,
  input  logic [lbb_pkg::PIX_W-1:0] s_tdata,
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lbb_pkg::PIX_W-1:0] m_tdata,
  output logic                      m_tlast,
  input  lbb_pkg::cmd_t             cmd,
  output lbb_pkg::sts_t             sts
);

  localparam int HW      = $clog2(MAX_WINDOW);
  localparam int PAD_LIM = (MAX_WINDOW - 1) / 2;
  localparam logic [4:0] LAST_TAP = 5'(MAX_WINDOW - 1);

  logic [lbb_pkg::WS_W-1:0]   window_size;
  logic [lbb_pkg::PIX_W-1:0]  hist [MAX_WINDOW];
  logic [lbb_pkg::SEEN_W-1:0] pixels_seen;
  logic [lbb_pkg::SEEN_W-1:0] idx;
  logic [lbb_pkg::PAD_W-1:0]  pad;
  logic [lbb_pkg::PAD_W-1:0]  centre;
  logic                       last_line;
  logic [lbb_pkg::TAP_W-1:0]  tap;
  logic [lbb_pkg::SUM_W-1:0]  sum;
  logic [lbb_pkg::QBITS-1:0]  quot;
  logic [lbb_pkg::QCNT_W-1:0] qcnt;

  logic [lbb_pkg::PAD_W-1:0]  ws_half;
  logic [lbb_pkg::PAD_W-1:0]  pad_cur;
  logic [lbb_pkg::PAD_W-1:0]  centre_init;
  logic [5:0]                 dd;
  logic [4:0]                 dpos;
  logic [4:0]                 dsel;
  logic [lbb_pkg::PIX_W-1:0]  tap_pix;
  logic [lbb_pkg::TAP_W-1:0]  tap_end;
  logic [lbb_pkg::WS_W-1:0]   divisor;
  logic [lbb_pkg::SUM_W-1:0]  div_sub;
  logic                       div_ge;

  // Window size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= lbb_pkg::WS_RESET;
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  // Pad of the current window, limited by the history depth.
  always_comb begin
    ws_half = window_size[lbb_pkg::WS_W-1:1];
    if (int'(ws_half) > PAD_LIM) begin
      pad_cur = lbb_pkg::PAD_W'(PAD_LIM);
    end else begin
      pad_cur = ws_half;
    end
    if (s_tlast && (pixels_seen < {1'b0, pad_cur})) begin
      centre_init = pixels_seen[lbb_pkg::PAD_W-1:0];
    end else begin
      centre_init = pad_cur;
    end
  end

  // Tap offset from the newest pixel, clamped to both line ends and to the
  // depth of the history.
  always_comb begin
    dd   = {3'b000, centre} + {2'b00, tap} - {3'b000, pad};
    dpos = dd[5] ? 5'd0 : dd[4:0];
    if (dpos > {1'b0, idx}) begin
      dpos = {1'b0, idx};
    end
    dsel = (dpos > LAST_TAP) ? LAST_TAP : dpos;
    tap_pix = hist[dsel[HW-1:0]];
  end

  // Quotient bit qcnt is decided against the divisor shifted up by qcnt.
  assign tap_end = {pad, 1'b0};
  assign divisor = {pad, 1'b1};
  assign div_sub = lbb_pkg::SUM_W'({divisor, 7'd0}) >> (lbb_pkg::QBITS - 1 - int'(qcnt));
  assign div_ge  = (sum >= div_sub);

  // History shift line and line position.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_seen <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.load) begin
      hist[0] <= s_tdata;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        hist[i] <= hist[i-1];
      end
      if (s_tlast) begin
        pixels_seen <= '0;
      end else if (pixels_seen < lbb_pkg::PIX_SAT) begin
        pixels_seen <= pixels_seen + 1'b1;
      end
    end
  end

  // Per-item context, accumulator and divider. The sum register doubles as
  // the partial remainder while dividing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx       <= pixels_seen;
      pad       <= pad_cur;
      centre    <= centre_init;
      last_line <= s_tlast;
    end else if (cmd.next_out) begin
      centre <= centre - 1'b1;
    end
    if (cmd.load || cmd.next_out) begin
      sum  <= '0;
      tap  <= '0;
      qcnt <= lbb_pkg::QCNT_W'(lbb_pkg::QBITS - 1);
    end else if (cmd.acc_step) begin
      sum <= sum + {4'd0, tap_pix};
      tap <= tap + 1'b1;
    end else if (cmd.div_step) begin
      if (div_ge) begin
        sum <= sum - div_sub;
      end
      quot <= {quot[lbb_pkg::QBITS-2:0], div_ge};
      qcnt <= qcnt - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= quot;
      m_tlast <= last_line && (centre == '0);
    end
  end

  assign sts.emit_first = s_tlast || ({1'b0, pad_cur} <= pixels_seen);
  assign sts.taps_done  = (tap == tap_end);
  assign sts.div_done   = (qcnt == '0);
  assign sts.more_out   = last_line && (centre != '0);
  assign sts.out_free   = !m_tvalid || m_tready;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("result pushed over a pending output");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_step |-> (tap <= tap_end))
    else $error("tap counter ran past the window");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load && s_tlast |=> (pixels_seen == '0))
    else $error("line position not cleared at end of line");

  a_seen_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !s_tlast && (pixels_seen < lbb_pkg::PIX_SAT)
      |=> (pixels_seen == $past(pixels_seen) + 1'b1))
    else $error("line position did not advance");
`endif

endmodule

// ===== test/tb_line_box_blur.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_line_box_blur: self-checking testbench for the line box blur
// Streams lines of pixels through the block under several window sizes and
// idle patterns, predicts every blurred output in a scoreboard class and
// compares each output transaction field by field in arrival order.
// ============================================================================
module tb_line_box_blur;

  localparam int HIST_DEPTH  = lbb_pkg::MAX_WINDOW_DEF;
  localparam int CYCLE_LIMIT = 600000;
  // This pause lets the block settle before a window size write.
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 38;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {
    STYLE_RANDOM, STYLE_ZERO, STYLE_FULL, STYLE_ALTERNATE, STYLE_EXTREMES
  } line_style_e;

  // Tracks the blur state of the block and holds the outputs still owed.
  class blur_checker;
    typedef struct {
      logic [lbb_pkg::PIX_W-1:0] pix;
      logic                      last;
    } blur_out_t;

    logic [lbb_pkg::PIX_W-1:0]  history [HIST_DEPTH];
    logic [lbb_pkg::SEEN_W-1:0] seen;
    logic [lbb_pkg::WS_W-1:0]   window;
    blur_out_t                  owed_outputs [$];
    int                         mismatches;

    function new();
      window = lbb_pkg::WS_RESET;
      seen = '0;
      mismatches = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void set_window(logic [lbb_pkg::WS_W-1:0] ws);
      window = ws;
    endfunction

    function int owed_count();
      return owed_outputs.size();
    endfunction

    function int pad_now();
      int p;
      p = window >> 1;
      if (p > (HIST_DEPTH - 1) / 2) p = (HIST_DEPTH - 1) / 2;
      return p;
    endfunction

    // Average of the window around a centre counted back from the newest
    // pixel; positions before the line start repeat the first pixel.
    function logic [lbb_pkg::PIX_W-1:0] blur_at(int centre, int pad, int newest);
      int sum;
      int d;
      logic [lbb_pkg::PIX_W-1:0] q;
      sum = 0;
      for (int t = -pad; t <= pad; t++) begin
        d = centre + t;
        if (d < 0) d = 0;
        if (d > newest) d = newest;
        if (d > HIST_DEPTH - 1) d = HIST_DEPTH - 1;
        sum += history[d];
      end
      q = sum / (2 * pad + 1);
      return q;
    endfunction

    function void take_pixel(logic [lbb_pkg::PIX_W-1:0] pix, logic line_end);
      int pad;
      int idx;
      blur_out_t o;
      pad = pad_now();
      idx = seen;
      for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = pix;
      if (!line_end) begin
        if (idx >= pad) begin
          o.pix = blur_at(pad, pad, idx);
          o.last = 1'b0;
          owed_outputs.push_back(o);
        end
        if (seen != lbb_pkg::PIX_SAT) seen = seen + 1'b1;
      end else begin
        // The last pixel releases every pending output; positions past the
        // line end repeat the last pixel.
        for (int c = (pad < idx) ? pad : idx; c >= 0; c--) begin
          o.pix = blur_at(c, pad, idx);
          o.last = (c == 0);
          owed_outputs.push_back(o);
        end
        seen = '0;
      end
    endfunction

    function void note_mismatch(string what, blur_out_t e,
                                logic [lbb_pkg::PIX_W-1:0] pix, logic last);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): expected pixel %0d last %0b, got pixel %0d last %0b",
                 what, e.pix, e.last, pix, last);
    endfunction

    function void check_output(logic [lbb_pkg::PIX_W-1:0] pix, logic last);
      blur_out_t e;
      if (owed_outputs.size() == 0) begin
        e.pix = 'x;
        e.last = 1'bx;
        note_mismatch("unexpected output", e, pix, last);
      end else begin
        e = owed_outputs.pop_front();
        if (e.pix !== pix || e.last !== last) note_mismatch("wrong field", e, pix, last);
      end
    endfunction
  endclass

  // All inputs start at known values.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen = 1'b0;
  logic [lbb_pkg::WS_W-1:0]  cfg_wdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [lbb_pkg::PIX_W-1:0] s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [lbb_pkg::PIX_W-1:0] m_tdata;
  logic                      m_tlast;

  blur_checker chk;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;

  // State of the line being generated; lines run across phase boundaries,
  // so a window size change can land in the middle of a line.
  int          line_left = 0;
  int          line_pos = 0;
  line_style_e line_style = STYLE_RANDOM;

  line_box_blur i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // pixel_in
    .s_tlast   (s_tlast),    // line_end
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // pixel_out
    .m_tlast   (m_tlast)     // last_out
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a correct run finishes far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL line_box_blur");
      $finish;
    end
  end

  // Output side: check every output transaction, then decide at random
  // whether to stall the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) chk.check_output(m_tdata, m_tlast);
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Present one pixel after a random gap and wait for its transaction. The
  // valid is left high on return, so the caller lowers it in the same time
  // step when no further pixel follows at once.
  task automatic send_pixel(input logic [lbb_pkg::PIX_W-1:0] pix, input logic line_end);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tlast <= line_end;
    do @(posedge clk); while (!s_tready);
    chk.take_pixel(pix, line_end);
  endtask

  // Write the window size once every owed output has come back and the block
  // has had time to finish any pixel that released nothing.
  task automatic write_window(input logic [lbb_pkg::WS_W-1:0] ws);
    while (chk.owed_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= ws;
    @(posedge clk);
    cfg_wen <= 1'b0;
    chk.set_window(ws);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 61;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 61;
      end
      default: begin
        send_idle_pct = 37;
        recv_stall_pct = 37;
      end
    endcase
  endtask

  function automatic logic [lbb_pkg::PIX_W-1:0] line_pixel(line_style_e style, int pos);
    case (style)
      STYLE_ZERO:      return 8'h00;
      STYLE_FULL:      return 8'hFF;
      STYLE_ALTERNATE: return pos[0] ? 8'hFF : 8'h00;
      STYLE_EXTREMES: begin
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default:         return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short lines, some longer than the history so the pixel count
  // saturates, and a few long ones.
  task automatic start_line();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) line_left = $urandom_range(1, 8);
    else if (r < 9) line_left = $urandom_range(9, 20);
    else line_left = $urandom_range(21, 40);
    line_pos = 0;
    if ($urandom_range(0, 1)) line_style = STYLE_RANDOM;
    else line_style = line_style_e'($urandom_range(STYLE_ZERO, STYLE_EXTREMES));
  endtask

  initial begin
    logic [lbb_pkg::WS_W-1:0]  window_plan [RANDOM_PHASES];
    logic [lbb_pkg::PIX_W-1:0] pix;

    chk = new();
    // Plan: pass-through sizes, the largest, even sizes and the odd range.
    window_plan = '{4'd0, 4'd1, 4'd15, 4'd4, 4'd3, 4'd7,
                    4'd14, 4'd8, 4'd2, 4'd9, 4'd13, 4'd0};
    window_plan[RANDOM_PHASES-1] = 4'($urandom_range(0, 15));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset window of three: extreme pixel values,
    // a single-pixel line and a two-pixel line.
    set_idle(IDLE_NONE);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b1);
    s_tvalid <= 1'b0;

    // Largest window: a full-scale line shorter than the window (maximum
    // sum and edge replication at both ends), a single pixel, and a line
    // long enough to release outputs before its end.
    write_window(4'd15);
    repeat (5) send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 8'h00 : 8'hFF, i == 8);
    s_tvalid <= 1'b0;

    // Random part: each phase has its own window size and idle pattern.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_window(window_plan[ph]);
      set_idle(idle_mode_e'(ph % 4));
      repeat (PHASE_ITEMS) begin
        if (line_left == 0) start_line();
        pix = line_pixel(line_style, line_pos);
        send_pixel(pix, line_left == 1);
        line_left--;
        line_pos++;
      end
      s_tvalid <= 1'b0;
    end

    // Drain, then give the block time to show any stray output.
    set_idle(IDLE_NONE);
    while (chk.owed_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 20) @(posedge clk);
    if (chk.mismatches == 0 && chk.owed_count() == 0) begin
      $display("PASS line_box_blur");
    end else begin
      $display("FAIL line_box_blur");
    end
    $finish;
  end

endmodule
